[src/pdc_pkg.sv]
// Shared types, widths, register codes and reset values for the dead-time compensation block.
package pdc_pkg;

    localparam int DUTY_FRAC_BITS_DEF   = 16;
    localparam int FILTER_FRAC_BITS_DEF = 16;

    localparam int NUM_PHASES = 3;
    localparam int DUTY_W     = 17;
    localparam int CUR_W      = 16;
    localparam int SIGN_W     = 2;
    localparam int FC_FRAC    = 16;
    localparam int FC_W       = 32;

    localparam int GAIN_W   = 17;
    localparam int MARGIN_W = 16;
    localparam int BAND_W   = 15;
    localparam int ALPHA_W  = 16;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 17;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;
    localparam int S_CUR_LSB = NUM_PHASES * DUTY_W;
    localparam int M_POL_LSB = NUM_PHASES * DUTY_W;

    localparam logic [DUTY_W-1:0] DUTY_FIELD_MAX = '1;

    typedef logic [SIGN_W-1:0] t_sign;
    localparam t_sign SIGN_ZERO = 2'b00;
    localparam t_sign SIGN_POS  = 2'b01;
    localparam t_sign SIGN_NEG  = 2'b11;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index REG_COMP_GAIN    = 8'd0;
    localparam t_cfg_index REG_DUTY_MARGIN  = 8'd1;
    localparam t_cfg_index REG_HYST_BAND    = 8'd2;
    localparam t_cfg_index REG_FILTER_ALPHA = 8'd3;

    localparam logic [GAIN_W-1:0]   COMP_GAIN_RST    = 17'd0;
    localparam logic [MARGIN_W-1:0] DUTY_MARGIN_RST  = 16'd0;
    localparam logic [BAND_W-1:0]   HYST_BAND_RST    = 15'd50;
    localparam logic [ALPHA_W-1:0]  FILTER_ALPHA_RST = 16'd55706;

endpackage

[src/pwm_deadtime_compensation.sv]
// Three-phase inverter dead-time compensation: current filter, sign detection, duty correction.
//
// One input transaction carries three commanded duties and three phase currents; one output
// transaction returns three compensated duties and three detected current signs. The block
// takes one transaction per clock cycle, sustained, while the output is not stalled, and a result
// passes the input register, filter/sign register and output register in turn. The rate is set
// by the per-phase filter update, a single 33x17 multiply plus add that closes its feedback
// loop combinationally, so consecutive items of the same phase follow each other back to back.
// Each stage holds while the stage after it is full and stalled, so the input side keeps
// taking transactions until all three stages are occupied. The filter keeps the current in
// Q16.16 and moves toward each new sample by (1 - alpha); a sign flips to +1 or -1 only when
// the filtered current leaves the hysteresis band, and stays 0 until the first such crossing.
// With sign 0 the duty passes uncorrected. The corrected duty is clamped to the lower bound
// (margin) first and then to the upper bound (one minus margin). Configuration is written
// through a separate valid/ready channel, always ready; write it only while the pipeline is
// empty. Unknown register indexes are ignored.
module pwm_deadtime_compensation #(
    parameter int DUTY_FRAC_BITS   = pdc_pkg::DUTY_FRAC_BITS_DEF,
    parameter int FILTER_FRAC_BITS = pdc_pkg::FILTER_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // duty_in_a[16:0], duty_in_b[33:17], duty_in_c[50:34],
    // current_a[66:51], current_b[82:67], current_c[98:83], zero fill [103:99]
    input  logic [pdc_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,

    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // duty_out_a[16:0], duty_out_b[33:17], duty_out_c[50:34],
    // polarity_a[52:51], polarity_b[54:53], polarity_c[56:55], zero fill [63:57]
    output logic [pdc_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pdc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NP     = pdc_pkg::NUM_PHASES;
    localparam int DUTY_W = pdc_pkg::DUTY_W;
    localparam int CUR_W  = pdc_pkg::CUR_W;
    localparam int FC_W   = pdc_pkg::FC_W;

    // filter arithmetic widths
    localparam int KW = FILTER_FRAC_BITS + 1;
    localparam int WW = (KW > pdc_pkg::ALPHA_W) ? KW : pdc_pkg::ALPHA_W;
    localparam int DW = FC_W + 1;
    localparam int PW = DW + KW + 1;
    localparam logic [WW-1:0] ONE_F = {{(WW-1){1'b0}}, 1'b1} << FILTER_FRAC_BITS;
    localparam logic signed [PW-1:0] HALF_F =
        {{(PW-1){1'b0}}, 1'b1} << (FILTER_FRAC_BITS - 1);

    // compensation arithmetic width: covers duty +/- gain and one - margin, signed
    localparam int CW = (((DUTY_FRAC_BITS + 2) > 19) ? (DUTY_FRAC_BITS + 2) : 19) + 1;
    localparam logic signed [CW-1:0] ONE_D = {{(CW-1){1'b0}}, 1'b1} << DUTY_FRAC_BITS;
    localparam logic signed [CW-1:0] MAX_D = {{(CW-DUTY_W){1'b0}}, pdc_pkg::DUTY_FIELD_MAX};

    // configuration registers
    logic [pdc_pkg::GAIN_W-1:0]   r_comp_gain;
    logic [pdc_pkg::MARGIN_W-1:0] r_duty_margin;
    logic [pdc_pkg::BAND_W-1:0]   r_hyst_band;
    logic [pdc_pkg::ALPHA_W-1:0]  r_filter_alpha;

    // per-phase state
    logic signed [FC_W-1:0] r_fc [NP];
    pdc_pkg::t_sign         r_sign [NP];
    logic signed [FC_W-1:0] n_fc [NP];
    pdc_pkg::t_sign         n_sign [NP];

    // pipeline registers
    logic                    r_in_valid;
    logic [DUTY_W-1:0]       r_in_duty [NP];
    logic signed [CUR_W-1:0] r_in_cur [NP];

    logic                    r_mid_valid;
    logic [DUTY_W-1:0]       r_mid_duty [NP];
    pdc_pkg::t_sign          r_mid_sign [NP];

    logic                    r_out_valid;
    logic [DUTY_W-1:0]       r_out_duty [NP];
    pdc_pkg::t_sign          r_out_pol [NP];
    logic [DUTY_W-1:0]       n_out_duty [NP];

    logic in_ready;
    logic mid_ready;
    logic out_ready;

    // filter intermediates
    logic [WW-1:0]          alpha_ext;
    logic [WW-1:0]          w_lim;
    logic [WW-1:0]          k_full;
    logic [KW-1:0]          k_coef;
    logic signed [FC_W-1:0] x_q [NP];
    logic signed [DW-1:0]   diff [NP];
    logic signed [PW-1:0]   prod [NP];
    logic signed [PW-1:0]   adj [NP];
    logic signed [DW-1:0]   fc_ext [NP];
    logic signed [DW-1:0]   band_pos;
    logic signed [DW-1:0]   band_neg;

    // compensation intermediates
    logic signed [CW-1:0] comp_d [NP];
    logic signed [CW-1:0] gain_d;
    logic signed [CW-1:0] margin_d;
    logic signed [CW-1:0] upper_d;

    // ---------------------------------------------------------------- handshake
    // Each stage takes a new item when it is empty or its content moves on.
    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign mid_ready       = !r_mid_valid || out_ready;
    assign in_ready        = !r_in_valid || mid_ready;
    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_cfg_ready     = 1'b1;

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_gain    <= pdc_pkg::COMP_GAIN_RST;
            r_duty_margin  <= pdc_pkg::DUTY_MARGIN_RST;
            r_hyst_band    <= pdc_pkg::HYST_BAND_RST;
            r_filter_alpha <= pdc_pkg::FILTER_ALPHA_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pdc_pkg::REG_COMP_GAIN: begin
                    r_comp_gain <= i_cfg_data[pdc_pkg::GAIN_W-1:0];
                end
                pdc_pkg::REG_DUTY_MARGIN: begin
                    r_duty_margin <= i_cfg_data[pdc_pkg::MARGIN_W-1:0];
                end
                pdc_pkg::REG_HYST_BAND: begin
                    r_hyst_band <= i_cfg_data[pdc_pkg::BAND_W-1:0];
                end
                pdc_pkg::REG_FILTER_ALPHA: begin
                    r_filter_alpha <= i_cfg_data[pdc_pkg::ALPHA_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            for (int ph = 0; ph < NP; ph++) begin
                r_in_duty[ph] <= i_s_axis_tdata[ph*DUTY_W +: DUTY_W];
                r_in_cur[ph]  <= i_s_axis_tdata[pdc_pkg::S_CUR_LSB + ph*CUR_W +: CUR_W];
            end
        end
    end

    // ---------------------------------------------------------------- filter and sign
    // f' = f + round_half_up((1 - w) * (x - f)), the same as the weighted mean of f and x.
    always_comb begin
        alpha_ext = WW'(r_filter_alpha);
        w_lim     = (alpha_ext > ONE_F) ? ONE_F : alpha_ext;
        k_full    = ONE_F - w_lim;
        k_coef    = k_full[KW-1:0];
        band_pos  = {2'b00, r_hyst_band, {pdc_pkg::FC_FRAC{1'b0}}};
        band_neg  = -band_pos;
        for (int ph = 0; ph < NP; ph++) begin
            x_q[ph]    = {r_in_cur[ph], {pdc_pkg::FC_FRAC{1'b0}}};
            diff[ph]   = {x_q[ph][FC_W-1], x_q[ph]} - {r_fc[ph][FC_W-1], r_fc[ph]};
            prod[ph]   = $signed({1'b0, k_coef}) * diff[ph];
            adj[ph]    = (prod[ph] + HALF_F) >>> FILTER_FRAC_BITS;
            n_fc[ph]   = r_fc[ph] + adj[ph][FC_W-1:0];
            fc_ext[ph] = {n_fc[ph][FC_W-1], n_fc[ph]};
            if (fc_ext[ph] > band_pos) begin
                n_sign[ph] = pdc_pkg::SIGN_POS;
            end else if (fc_ext[ph] < band_neg) begin
                n_sign[ph] = pdc_pkg::SIGN_NEG;
            end else begin
                n_sign[ph] = r_sign[ph];
            end
        end
    end

    // State advances exactly once per item, when it moves into the middle stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ph = 0; ph < NP; ph++) begin
                r_fc[ph]   <= '0;
                r_sign[ph] <= pdc_pkg::SIGN_ZERO;
            end
        end else if (r_in_valid && mid_ready) begin
            for (int ph = 0; ph < NP; ph++) begin
                r_fc[ph]   <= n_fc[ph];
                r_sign[ph] <= n_sign[ph];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_ready) begin
            r_mid_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && mid_ready) begin
            for (int ph = 0; ph < NP; ph++) begin
                r_mid_duty[ph] <= r_in_duty[ph];
                r_mid_sign[ph] <= n_sign[ph];
            end
        end
    end

    // ---------------------------------------------------------------- compensation and clamp
    always_comb begin
        gain_d   = {{(CW-pdc_pkg::GAIN_W){1'b0}}, r_comp_gain};
        margin_d = {{(CW-pdc_pkg::MARGIN_W){1'b0}}, r_duty_margin};
        upper_d  = ONE_D - margin_d;
        for (int ph = 0; ph < NP; ph++) begin
            comp_d[ph] = {{(CW-DUTY_W){1'b0}}, r_mid_duty[ph]};
            case (r_mid_sign[ph])
                pdc_pkg::SIGN_POS: comp_d[ph] = comp_d[ph] + gain_d;
                pdc_pkg::SIGN_NEG: comp_d[ph] = comp_d[ph] - gain_d;
                default:           comp_d[ph] = comp_d[ph];
            endcase
            // lower bound first, so a margin above half ends at the upper bound
            if (comp_d[ph] < margin_d) begin
                comp_d[ph] = margin_d;
            end
            if (comp_d[ph] > upper_d) begin
                comp_d[ph] = upper_d;
            end
            if (comp_d[ph] < 0) begin
                comp_d[ph] = '0;
            end
            if (comp_d[ph] > MAX_D) begin
                comp_d[ph] = MAX_D;
            end
            n_out_duty[ph] = comp_d[ph][DUTY_W-1:0];
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mid_valid && out_ready) begin
            for (int ph = 0; ph < NP; ph++) begin
                r_out_duty[ph] <= n_out_duty[ph];
                r_out_pol[ph]  <= r_mid_sign[ph];
            end
        end
    end

    always_comb begin
        o_m_axis_tdata = '0;
        for (int ph = 0; ph < NP; ph++) begin
            o_m_axis_tdata[ph*DUTY_W +: DUTY_W] = r_out_duty[ph];
            o_m_axis_tdata[pdc_pkg::M_POL_LSB + ph*pdc_pkg::SIGN_W +: pdc_pkg::SIGN_W] =
                r_out_pol[ph];
        end
    end

    // ---------------------------------------------------------------- assertions
    // Once a sign is detected it never drops back to zero.
    for (genvar g = 0; g < NP; g++) begin : g_sign_chk
        a_sign_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_sign[g] != pdc_pkg::SIGN_ZERO) |=> (r_sign[g] != pdc_pkg::SIGN_ZERO))
            else $error("phase sign returned to zero");
    end

    // The sign carried down the pipe is the one just stored in the phase state.
    a_mid_sign_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && mid_ready) |=>
            (r_mid_valid && r_mid_sign[0] == r_sign[0] && r_mid_sign[1] == r_sign[1]
             && r_mid_sign[2] == r_sign[2]))
        else $error("middle stage sign differs from phase state");

    // A valid result never carries the unused sign code.
    a_pol_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pol[0] != 2'b10 && r_out_pol[1] != 2'b10
                         && r_out_pol[2] != 2'b10))
        else $error("invalid polarity code on output");

    // A stalled middle stage keeps its item.
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_valid && !out_ready) |=> r_mid_valid)
        else $error("middle stage item lost under stall");

endmodule
